@@ rtl/core/x86ea_pkg.sv @@
`timescale 1ns / 1ps

package x86ea_pkg;

   typedef enum logic {
      OP_WRITE_REG = 1'b0,
      OP_DECODE    = 1'b1
   } op_type;

   // ModR/M mod field
   localparam logic [1:0] MOD_NO_DISP = 2'd0;
   localparam logic [1:0] MOD_DISP8   = 2'd1;
   localparam logic [1:0] MOD_DISP32  = 2'd2;
   localparam logic [1:0] MOD_REG     = 2'd3;

   // general register numbers
   localparam logic [2:0] REG_EBX = 3'd3;
   localparam logic [2:0] REG_ESP = 3'd4;
   localparam logic [2:0] REG_EBP = 3'd5;
   localparam logic [2:0] REG_ESI = 3'd6;
   localparam logic [2:0] REG_EDI = 3'd7;

   // rm / SIB codes with special meaning
   localparam logic [2:0] RM_SIB       = 3'd4;
   localparam logic [2:0] RM_DISP32    = 3'd5;
   localparam logic [2:0] RM16_DISP16  = 3'd6;
   localparam logic [2:0] SIB_NO_INDEX = 3'd4;
   localparam logic [2:0] SIB_NO_BASE  = 3'd5;

   // displacement lengths in bytes
   localparam logic [2:0] DISP_NONE  = 3'd0;
   localparam logic [2:0] DISP_BYTE  = 3'd1;
   localparam logic [2:0] DISP_WORD  = 3'd2;
   localparam logic [2:0] DISP_DWORD = 3'd4;

   localparam logic [2:0] SEG_SS = 3'd2;

   typedef struct packed {
      op_type      operation;
      logic [2:0]  reg_number;
      logic [31:0] reg_value;
      logic [7:0]  modrm_byte;
      logic [7:0]  sib_byte;
      logic [31:0] disp_raw;
      logic        addr_32;
      logic        seg_prefix;
      logic [2:0]  current_seg;
   } req_type;

   typedef struct packed {
      logic        is_reg_operand;
      logic [2:0]  rm_register;
      logic        uses_sib;
      logic [2:0]  disp_length;
      logic [31:0] eff_offset;
      logic [2:0]  eff_segment;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic        is_write;
      logic [2:0]  reg_num;      // write target, or rm register for reg operand
      logic [31:0] value;        // write data, or extended displacement
      logic        is_reg_operand;
      logic        uses_sib;
      logic [2:0]  disp_length;
      logic        base_en;
      logic [2:0]  base_sel;
      logic        index_en;
      logic [2:0]  index_sel;
      logic [1:0]  scale;
      logic        wrap16;
      logic [2:0]  seg;
   } desc_type;

endpackage

@@ rtl/core/x86_modrm_effective_address.sv @@
`timescale 1ns / 1ps

// x86 ModR/M / SIB effective address unit. Two item kinds enter on the req_
// queue port: a register write loads one of the eight 32-bit general registers
// and gives no result; a decode item gives exactly one result on the rsp_ queue
// port (register-or-memory, rm register, SIB use, displacement length, offset,
// segment), in the order the items were accepted. One item can transfer on
// every clock while req_full is low; a decode result passes through the
// classify queue, register read stage and address add into the result queue.
// A register write takes effect before any later decode item reads registers,
// so write-then-decode back to back needs no gap. Full and empty are driven
// straight from registers. Sixteen-bit offsets wrap at 16 bits; BP, EBP and
// ESP bases select SS unless a segment prefix is present.

module x86_modrm_effective_address (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  x86ea_pkg::req_type  req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output x86ea_pkg::rsp_type  rsp_data
);

   logic                desc_valid;
   logic                desc_pop;
   x86ea_pkg::desc_type desc_data;

   // front end: classify ModR/M/SIB into a base/index/displacement recipe
   x86ea_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .desc_pop   (desc_pop),
      .desc_valid (desc_valid),
      .desc_data  (desc_data)
   );

   // back end: register file, address add and result queue
   x86ea_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc_pop   (desc_pop),
      .desc_data  (desc_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/core/x86ea_front.sv @@
`timescale 1ns / 1ps

module x86ea_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  x86ea_pkg::req_type   req_data,
   input  logic                 desc_pop,
   output logic                 desc_valid,
   output x86ea_pkg::desc_type  desc_data
);

   x86ea_pkg::desc_type cls;
   logic [1:0]          md;
   logic [2:0]          rm;
   logic [2:0]          sib_base;
   logic [2:0]          sib_index;
   logic [2:0]          len;
   logic                ss;

   // classify
   always_comb begin
      md        = req_data.modrm_byte[7:6];
      rm        = req_data.modrm_byte[2:0];
      sib_base  = req_data.sib_byte[2:0];
      sib_index = req_data.sib_byte[5:3];
      len       = x86ea_pkg::DISP_NONE;
      ss        = 1'b0;
      cls       = '0;
      cls.is_write = (req_data.operation == x86ea_pkg::OP_WRITE_REG);
      cls.reg_num  = req_data.reg_number;
      cls.value    = req_data.reg_value;
      if (!cls.is_write) begin
         cls.reg_num = '0;
         if (md == x86ea_pkg::MOD_REG) begin
            cls.is_reg_operand = 1'b1;
            cls.reg_num        = rm;
         end else if (!req_data.addr_32) begin
            cls.wrap16 = 1'b1;
            if (md == x86ea_pkg::MOD_DISP8) begin
               len = x86ea_pkg::DISP_BYTE;
            end else if (md == x86ea_pkg::MOD_DISP32 || rm == x86ea_pkg::RM16_DISP16) begin
               len = x86ea_pkg::DISP_WORD;
            end
            // bx/bp are the base, si/di the index; a lone si, di, bp or bx is the base
            case (rm)
               3'd0: begin
                  cls.base_en = 1'b1; cls.base_sel = x86ea_pkg::REG_EBX;
                  cls.index_en = 1'b1; cls.index_sel = x86ea_pkg::REG_ESI;
               end
               3'd1: begin
                  cls.base_en = 1'b1; cls.base_sel = x86ea_pkg::REG_EBX;
                  cls.index_en = 1'b1; cls.index_sel = x86ea_pkg::REG_EDI;
               end
               3'd2: begin
                  cls.base_en = 1'b1; cls.base_sel = x86ea_pkg::REG_EBP;
                  cls.index_en = 1'b1; cls.index_sel = x86ea_pkg::REG_ESI;
                  ss = 1'b1;
               end
               3'd3: begin
                  cls.base_en = 1'b1; cls.base_sel = x86ea_pkg::REG_EBP;
                  cls.index_en = 1'b1; cls.index_sel = x86ea_pkg::REG_EDI;
                  ss = 1'b1;
               end
               3'd4: begin
                  cls.base_en = 1'b1; cls.base_sel = x86ea_pkg::REG_ESI;
               end
               3'd5: begin
                  cls.base_en = 1'b1; cls.base_sel = x86ea_pkg::REG_EDI;
               end
               3'd6: begin
                  if (md != x86ea_pkg::MOD_NO_DISP) begin
                     cls.base_en = 1'b1; cls.base_sel = x86ea_pkg::REG_EBP;
                     ss = 1'b1;
                  end
               end
               default: begin
                  cls.base_en = 1'b1; cls.base_sel = x86ea_pkg::REG_EBX;
               end
            endcase
         end else begin
            if (md == x86ea_pkg::MOD_DISP8) begin
               len = x86ea_pkg::DISP_BYTE;
            end else if (md == x86ea_pkg::MOD_DISP32 || rm == x86ea_pkg::RM_DISP32) begin
               len = x86ea_pkg::DISP_DWORD;
            end
            if (rm == x86ea_pkg::RM_SIB) begin
               cls.uses_sib = 1'b1;
               cls.scale    = req_data.sib_byte[7:6];
               if (sib_index != x86ea_pkg::SIB_NO_INDEX) begin
                  cls.index_en  = 1'b1;
                  cls.index_sel = sib_index;
               end
               if (sib_base == x86ea_pkg::SIB_NO_BASE) begin
                  if (md == x86ea_pkg::MOD_NO_DISP) begin
                     len = x86ea_pkg::DISP_DWORD;
                  end else begin
                     cls.base_en  = 1'b1;
                     cls.base_sel = x86ea_pkg::REG_EBP;
                     ss           = 1'b1;
                  end
               end else begin
                  cls.base_en  = 1'b1;
                  cls.base_sel = sib_base;
                  ss           = (sib_base == x86ea_pkg::REG_ESP);
               end
            end else if (!(rm == x86ea_pkg::RM_DISP32 && md == x86ea_pkg::MOD_NO_DISP)) begin
               cls.base_en  = 1'b1;
               cls.base_sel = rm;
               ss           = (rm == x86ea_pkg::REG_EBP);
            end
         end
         cls.disp_length = len;
         case (len)
            x86ea_pkg::DISP_BYTE:  cls.value = {{24{req_data.disp_raw[7]}},
                                                req_data.disp_raw[7:0]};
            x86ea_pkg::DISP_WORD:  cls.value = {16'h0000, req_data.disp_raw[15:0]};
            x86ea_pkg::DISP_DWORD: cls.value = req_data.disp_raw;
            default:               cls.value = '0;
         endcase
         if (!cls.is_reg_operand) begin
            cls.seg = (ss && !req_data.seg_prefix) ? x86ea_pkg::SEG_SS
                                                    : req_data.current_seg;
         end
      end
   end

   // two-entry queue toward the back end
   x86ea_pkg::desc_type head_ff, head_in, tail_ff, tail_in;
   logic [1:0]          count_ff, count_in;
   logic                do_push, do_pop;

   assign req_full   = (count_ff == 2'd2);
   assign desc_valid = (count_ff != 2'd0);
   assign desc_data  = head_ff;
   assign do_push    = req_push && !req_full;
   assign do_pop     = desc_pop && desc_valid;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      if (do_pop && count_ff == 2'd2) begin
         head_in = tail_ff;
      end
      if (do_push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && do_pop)) begin
            head_in = cls;
         end else begin
            tail_in = cls;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

@@ rtl/core/x86ea_back.sv @@
`timescale 1ns / 1ps

module x86ea_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 desc_valid,
   output logic                 desc_pop,
   input  x86ea_pkg::desc_type  desc_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output x86ea_pkg::rsp_type   rsp_data
);

   // general registers; invalid entries read as zero until written
   logic [31:0]         gpr_ff [8];
   logic [7:0]          gpr_valid_ff, gpr_valid_in;

   // read stage
   logic                s1_valid_ff, s1_valid_in;
   x86ea_pkg::desc_type s1_desc_ff;
   logic [31:0]         s1_base_ff, s1_index_ff;
   logic                s1_base_ok_ff, s1_index_ok_ff;

   // result queue
   x86ea_pkg::rsp_type  out_head_ff, out_head_in, out_tail_ff, out_tail_in;
   logic [1:0]          out_count_ff, out_count_in;
   logic                out_push, out_pop, s1_free, gpr_write;

   x86ea_pkg::rsp_type  result;
   logic [31:0]         base_val, index_val, sum;

   assign out_pop   = rsp_pop && !rsp_empty;
   assign out_push  = s1_valid_ff && (out_count_ff != 2'd2);
   assign s1_free   = !s1_valid_ff || out_push;
   assign desc_pop  = desc_valid && s1_free;
   assign gpr_write = desc_pop && desc_data.is_write;

   always_comb begin
      gpr_valid_in = gpr_valid_ff;
      if (gpr_write) begin
         gpr_valid_in[desc_data.reg_num] = 1'b1;
      end
      s1_valid_in = s1_free ? (desc_pop && !desc_data.is_write) : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpr_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         gpr_valid_ff <= gpr_valid_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (gpr_write) begin
         gpr_ff[desc_data.reg_num] <= desc_data.value;
      end
      if (desc_pop && !desc_data.is_write) begin
         s1_desc_ff     <= desc_data;
         s1_base_ff     <= gpr_ff[desc_data.base_sel];
         s1_index_ff    <= gpr_ff[desc_data.index_sel];
         s1_base_ok_ff  <= gpr_valid_ff[desc_data.base_sel] && desc_data.base_en;
         s1_index_ok_ff <= gpr_valid_ff[desc_data.index_sel] && desc_data.index_en;
      end
   end

   // address add
   always_comb begin
      base_val  = s1_base_ok_ff  ? s1_base_ff  : '0;
      index_val = s1_index_ok_ff ? s1_index_ff : '0;
      sum       = (index_val << s1_desc_ff.scale) + base_val + s1_desc_ff.value;
      result                = '0;
      result.is_reg_operand = s1_desc_ff.is_reg_operand;
      result.rm_register    = s1_desc_ff.is_reg_operand ? s1_desc_ff.reg_num : 3'd0;
      result.uses_sib       = s1_desc_ff.uses_sib;
      result.disp_length    = s1_desc_ff.disp_length;
      result.eff_offset     = s1_desc_ff.wrap16 ? {16'h0000, sum[15:0]} : sum;
      result.eff_segment    = s1_desc_ff.seg;
   end

   assign rsp_empty = (out_count_ff == 2'd0);
   assign rsp_data  = out_head_ff;

   always_comb begin
      out_head_in  = out_head_ff;
      out_tail_in  = out_tail_ff;
      out_count_in = out_count_ff + {1'b0, out_push} - {1'b0, out_pop};
      if (out_pop && out_count_ff == 2'd2) begin
         out_head_in = out_tail_ff;
      end
      if (out_push) begin
         if (out_count_ff == 2'd0 || (out_count_ff == 2'd1 && out_pop)) begin
            out_head_in = result;
         end else begin
            out_tail_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff <= '0;
      end else begin
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      out_head_ff <= out_head_in;
      out_tail_ff <= out_tail_in;
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      out_count_ff == 2'd2 && !out_pop |=> out_count_ff == 2'd2)
      else $error("result queue lost an entry");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_push |=> s1_valid_ff && $stable(s1_desc_ff))
      else $error("read stage changed while stalled");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      gpr_write && !s1_valid_ff |=> !s1_valid_ff)
      else $error("register write produced a result");

   a_reg_operand_zero: assert property (@(posedge clock) disable iff (reset)
      out_push && s1_desc_ff.is_reg_operand |-> result.eff_offset == 32'd0)
      else $error("register operand with nonzero offset");

endmodule

@@ bench/tb_x86_modrm_effective_address.sv @@
`timescale 1ns / 1ps

// Testbench for the ModR/M / SIB effective address unit.
module tb_x86_modrm_effective_address;

   import x86ea_pkg::*;

   localparam int CLOCK_HALF  = 5;
   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 355;
   localparam int DRAIN_CYCLES = 10;

   // Keeps a shadow copy of the general registers and the queue of decode
   // results that the block still owes.
   class address_scoreboard;
      logic [31:0] gpr [8];
      rsp_type     owed_results [$];
      int          errors;

      function new();
         foreach (gpr[i]) gpr[i] = '0;
         errors = 0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // Note one transfer in: load a register, or work out the decode result.
      function void note_request(req_type r);
         rsp_type     res;
         logic [1:0]  mode;
         logic [2:0]  rm;
         logic [1:0]  scale;
         logic [2:0]  index;
         logic [2:0]  base;
         logic [31:0] disp;
         logic [31:0] sum;
         logic [31:0] bx, bp, si, di;
         logic        stack_default;

         if (r.operation == OP_WRITE_REG) begin
            gpr[r.reg_number] = r.reg_value;
            return;
         end

         res = '0;
         mode = r.modrm_byte[7:6];
         rm = r.modrm_byte[2:0];
         {scale, index, base} = r.sib_byte;
         stack_default = 1'b0;
         sum = '0;

         if (mode == MOD_REG) begin
            res.is_reg_operand = 1'b1;
            res.rm_register = rm;
            owed_results.push_back(res);
            return;
         end

         if (!r.addr_32) begin
            if (mode == MOD_DISP8) res.disp_length = DISP_BYTE;
            else if (mode == MOD_DISP32 || rm == RM16_DISP16) res.disp_length = DISP_WORD;
         end else begin
            if (mode == MOD_DISP8) res.disp_length = DISP_BYTE;
            else if (mode == MOD_DISP32 || rm == RM_DISP32) res.disp_length = DISP_DWORD;
            if (rm == RM_SIB) begin
               res.uses_sib = 1'b1;
               if (base == SIB_NO_BASE && mode == MOD_NO_DISP) res.disp_length = DISP_DWORD;
            end
         end

         case (res.disp_length)
            DISP_BYTE:  disp = {{24{r.disp_raw[7]}}, r.disp_raw[7:0]};
            DISP_WORD:  disp = {16'h0000, r.disp_raw[15:0]};
            DISP_DWORD: disp = r.disp_raw;
            default:    disp = '0;
         endcase

         if (!r.addr_32) begin
            // 16-bit forms work on the low halves of the registers
            bx = {16'h0000, gpr[REG_EBX][15:0]};
            bp = {16'h0000, gpr[REG_EBP][15:0]};
            si = {16'h0000, gpr[REG_ESI][15:0]};
            di = {16'h0000, gpr[REG_EDI][15:0]};
            case (rm)
               3'd0: sum = bx + si;
               3'd1: sum = bx + di;
               3'd2: begin
                  sum = bp + si;
                  stack_default = 1'b1;
               end
               3'd3: begin
                  sum = bp + di;
                  stack_default = 1'b1;
               end
               3'd4: sum = si;
               3'd5: sum = di;
               RM16_DISP16: begin
                  if (mode != MOD_NO_DISP) begin
                     sum = bp;
                     stack_default = 1'b1;
                  end
               end
               default: sum = bx;
            endcase
            sum = (sum + disp) & 32'h0000_FFFF;
         end else if (rm == RM_SIB) begin
            if (index != SIB_NO_INDEX) sum = gpr[index] << scale;
            if (base == SIB_NO_BASE) begin
               if (mode != MOD_NO_DISP) begin
                  sum = sum + gpr[REG_EBP];
                  stack_default = 1'b1;
               end
            end else begin
               sum = sum + gpr[base];
               if (base == REG_ESP) stack_default = 1'b1;
            end
            sum = sum + disp;
         end else if (rm == RM_DISP32 && mode == MOD_NO_DISP) begin
            sum = disp;
         end else begin
            if (rm == RM_DISP32) stack_default = 1'b1;
            sum = gpr[rm] + disp;
         end

         res.eff_offset = sum;
         res.eff_segment = (stack_default && !r.seg_prefix) ? SEG_SS : r.current_seg;
         owed_results.push_back(res);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
         end
      endfunction

      // Compare one transfer out against the oldest owed result.
      function void check_response(rsp_type got);
         rsp_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none got %h", $time, got);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         check_field("is_reg_operand", 32'(want.is_reg_operand), 32'(got.is_reg_operand));
         check_field("rm_register", 32'(want.rm_register), 32'(got.rm_register));
         check_field("uses_sib", 32'(want.uses_sib), 32'(got.uses_sib));
         check_field("disp_length", 32'(want.disp_length), 32'(got.disp_length));
         check_field("eff_offset", want.eff_offset, got.eff_offset);
         check_field("eff_segment", 32'(want.eff_segment), 32'(got.eff_segment));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   address_scoreboard sb = new();

   int stall_pct = 0;          // receiver: chance in a hundred of not popping
   int hold_off_cycles = 0;    // receiver: forced stretch of no pops
   int cycle_count = 0;

   x86_modrm_effective_address dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Hard stop in case a handshake hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_x86_modrm_effective_address: errors");
         $finish;
      end
   end

   // Receiver: checks each transfer out, then picks next cycle's pop.
   // Outputs are sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) sb.check_response(rsp_data);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic req_type reg_write(logic [2:0] num, logic [31:0] value);
      req_type r;
      r = '0;
      r.operation = OP_WRITE_REG;
      r.reg_number = num;
      r.reg_value = value;
      return r;
   endfunction

   function automatic req_type decode(logic [7:0] modrm, logic [7:0] sib, logic [31:0] disp,
                                      logic a32, logic prefix, logic [2:0] seg);
      req_type r;
      r = '0;
      r.operation = OP_DECODE;
      r.modrm_byte = modrm;
      r.sib_byte = sib;
      r.disp_raw = disp;
      r.addr_32 = a32;
      r.seg_prefix = prefix;
      r.current_seg = seg;
      return r;
   endfunction

   // Mostly decodes with fully random bytes; register writes keep the
   // shadow registers moving. Unused fields carry noise too.
   function automatic req_type random_item();
      req_type r;
      r.reg_number = 3'($urandom_range(7));
      r.reg_value = $urandom();
      r.modrm_byte = 8'($urandom_range(255));
      r.sib_byte = 8'($urandom_range(255));
      r.disp_raw = $urandom();
      r.addr_32 = 1'($urandom_range(1));
      r.seg_prefix = 1'($urandom_range(1));
      r.current_seg = 3'($urandom_range(7));
      r.operation = ($urandom_range(99) < 20) ? OP_WRITE_REG : OP_DECODE;
      return r;
   endfunction

   // Offer one item after a random idle stretch; return at its transfer edge.
   // push stays high into the next item when no idle cycle is drawn.
   task automatic send_item(req_type item, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic run_phase(int count, int idle_pct, int stall);
      stall_pct = stall;
      repeat (count) send_item(random_item(), idle_pct);
   endtask

   initial begin
      req_type directed [$];

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load every register with a distinct pattern, extremes included.
      directed.push_back(reg_write(3'd0, 32'hFFFF_FFFF));
      directed.push_back(reg_write(3'd1, 32'h8000_0001));
      directed.push_back(reg_write(3'd2, 32'h1234_5678));
      directed.push_back(reg_write(REG_EBX, 32'h0000_FFF0));
      directed.push_back(reg_write(REG_ESP, 32'h7FFF_FFFF));
      directed.push_back(reg_write(REG_EBP, 32'hDEAD_8000));
      directed.push_back(reg_write(REG_ESI, 32'h0001_0020));
      directed.push_back(reg_write(REG_EDI, 32'hCAFE_0004));
      // register operand, both address sizes
      directed.push_back(decode(8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7));
      directed.push_back(decode(8'hC0, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 3'd0));
      // 16-bit: direct disp16, negative disp8 with wrap, BP forms to SS
      directed.push_back(decode(8'h06, 8'h00, 32'h0000_BEEF, 1'b0, 1'b0, 3'd3));
      directed.push_back(decode(8'h40, 8'h00, 32'h0000_0080, 1'b0, 1'b0, 3'd3));
      directed.push_back(decode(8'h82, 8'h00, 32'h0000_FFFF, 1'b0, 1'b0, 3'd1));
      directed.push_back(decode(8'h46, 8'h00, 32'h0000_007F, 1'b0, 1'b1, 3'd6));
      directed.push_back(decode(8'h1C, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd4));
      directed.push_back(decode(8'h87, 8'h00, 32'h0000_FFFF, 1'b0, 1'b0, 3'd5));
      // 32-bit: direct disp32, SIB without base, ESP and EBP bases
      directed.push_back(decode(8'h05, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 3'd3));
      directed.push_back(decode(8'h04, 8'hE5, 32'h8000_0000, 1'b1, 1'b0, 3'd3));
      directed.push_back(decode(8'h44, 8'hCC, 32'h0000_0080, 1'b1, 1'b0, 3'd3));
      directed.push_back(decode(8'h84, 8'hB5, 32'h1234_5678, 1'b1, 1'b1, 3'd7));
      directed.push_back(decode(8'h45, 8'h00, 32'h0000_007F, 1'b1, 1'b0, 3'd0));
      directed.push_back(decode(8'h80, 8'h00, 32'h8000_0000, 1'b1, 1'b0, 3'd0));
      // SIB without index, plain register base, no displacement
      directed.push_back(decode(8'h04, 8'h20, 32'hFFFF_FFFF, 1'b1, 1'b0, 3'd5));
      directed.push_back(decode(8'h03, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd2));
      foreach (directed[i]) send_item(directed[i], 0);

      // Back to back, with a long receiver hold-off in the middle so the
      // block fills and drops full onto the sender.
      run_phase(RANDOM_PER_PHASE / 3, 0, 0);
      hold_off_cycles = 400;
      run_phase(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 3, 0, 0);
      // sparse sender, free receiver
      run_phase(RANDOM_PER_PHASE, 86, 0);
      // busy sender, mostly stalled receiver
      run_phase(RANDOM_PER_PHASE, 0, 86);
      // light gaps on both sides
      run_phase(RANDOM_PER_PHASE, 22, 22);
      req_push <= 1'b0;

      stall_pct = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0) begin
         $display("tb_x86_modrm_effective_address: clean");
      end else begin
         $display("tb_x86_modrm_effective_address: errors");
      end
      $finish;
   end

endmodule
